// ===== rtl/oeaf_pkg.sv =====
`timescale 1ns / 1ps
package oeaf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int US_W = 16;
    localparam int DER_W = 48;
    localparam int CFG_W = 32;
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 53;
    localparam int DIV_D_W = US_W;
    localparam int LOG2_EXP_DEPTH = 8;
    localparam int EXP_DEPTH = 1 << LOG2_EXP_DEPTH;
    localparam int ALPHA_W = 31;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam logic [MUL_B_W-1:0] TWO_PI_PER_MEGA_Q40 = 24'd6908435;
    localparam logic [MUL_B_W-1:0] LOG2E_Q16 = 24'd94548;
    localparam logic [MUL_B_W-1:0] MEGA = 24'd1000000;
    localparam logic [38:0] PROD_LIMIT = 39'h40_0000_0000;
    localparam logic [DER_W-1:0] DER_POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [DER_W-1:0] DER_NEG_LIM = 48'h8000_0000_0000;

    typedef enum logic [1:0] {
        CFG_MIN_CUTOFF = 2'd0,
        CFG_BETA       = 2'd1,
        CFG_D_CUTOFF   = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DMUL, ST_DIV, ST_DWAIT, ST_PMUL, ST_XMUL, ST_YMUL, ST_TAB,
        ST_FMUL, ST_INTERP, ST_ALPHA, ST_LPDIF, ST_LPLO, ST_LPHI, ST_LPSUM,
        ST_LPRES, ST_CABS, ST_CLO, ST_CHI, ST_CSUM, ST_DONE
    } state_t;

    typedef logic [ALPHA_W-1:0] exp_tab_t [EXP_DEPTH+1];

    // Long division by shift and subtract, used only while the table is built.
    function automatic longint unsigned const_quotient(longint unsigned num,
                                                       longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table of 2^(-k/EXP_DEPTH) in Q1.30, built from a truncated series for exp(-x).
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t tab;
        longint unsigned a;
        longint unsigned term;
        longint sum;
        for (int k = 0; k <= EXP_DEPTH; k++) begin
            a = (longint'(k) * LN2_Q30) >> LOG2_EXP_DEPTH;
            term = Q30_ONE;
            sum = longint'(Q30_ONE);
            for (int n = 1; n <= 20; n++) begin
                term = const_quotient((term * a) >> 30, longint'(n));
                if (n[0]) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = sum[ALPHA_W-1:0];
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP2_TAB = build_exp_tab();

endpackage

// ===== rtl/oeaf_mul.sv =====
`timescale 1ns / 1ps
module oeaf_mul
    import oeaf_pkg::*;
(
    input  logic               aclk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] p
);

    logic [MUL_P_W-1:0] p_reg;
    logic [MUL_P_W-1:0] p_next;

    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);
    assign p = p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

endmodule

// ===== rtl/oeaf_div.sv =====
`timescale 1ns / 1ps
module oeaf_div
    import oeaf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_D_W:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   shifted;

    assign done = done_reg;
    assign quotient = quo_reg;
    assign shifted = {rem_reg[DIV_D_W-1:0], quo_reg[DIV_N_W-1]};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
            cnt_next = CNT_W'(DIV_N_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                quo_next = {quo_reg[DIV_N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

// ===== rtl/one_euro_adaptive_filter.sv =====
`timescale 1ns / 1ps
// One Euro filter on a stream of signed Q16.16 samples, each with its interval in
// microseconds. The block handles one transaction at a time, and a sample is taken
// only once the previous one has left the final step. For each of the two smoothing
// coefficients that reaches one, the interpolation steps are skipped. The derivative
// is formed by a bit-serial divider, and the arithmetic steps use one shared 48 by 24
// bit multiplier that scales the sample difference by one million and evaluates the
// two smoothing coefficients, the two low-pass updates and the adaptive cutoff. The
// first sample after reset passes through unchanged and goes straight to the final
// step. The result sits in an output register, so a new sample is taken while it
// waits; a further result waits in the final step until the register is free, which
// holds off the input.
module one_euro_adaptive_filter
    import oeaf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [47:0]         s_tdata,    // sample[31:0], interval_us[47:32]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [SAMPLE_W-1:0] m_tdata,    // filtered[31:0]
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    state_t state_reg, state_next;
    logic                first_reg, first_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [DER_W-1:0]    sd_reg, sd_next;
    logic [SAMPLE_W-1:0] fv_reg, fv_next;
    logic [CFG_W-1:0]    min_cut_reg, min_cut_next;
    logic [CFG_W-1:0]    beta_reg, beta_next;
    logic [CFG_W-1:0]    dcut_reg, dcut_next;
    logic [SAMPLE_W-1:0] samp_reg, samp_next;
    logic [US_W-1:0]     us_reg, us_next;
    logic                neg_reg, neg_next;
    logic [32:0]         mag_reg, mag_next;
    logic                pass_reg, pass_next;
    logic [CFG_W-1:0]    fc_reg, fc_next;
    logic [5:0]          ip_reg, ip_next;
    logic [15:0]         fr_reg, fr_next;
    logic [ALPHA_W-1:0]  t0_reg, t0_next;
    logic [ALPHA_W-1:0]  dd_reg, dd_next;
    logic                dir_reg, dir_next;
    logic [ALPHA_W-1:0]  v_reg, v_next;
    logic [ALPHA_W-1:0]  alpha_reg, alpha_next;
    logic [DER_W:0]      lp_in_reg, lp_in_next;
    logic [DER_W:0]      lp_out_reg, lp_out_next;
    logic                ge_reg, ge_next;
    logic [DER_W-1:0]    md_reg, md_next;
    logic [MUL_P_W-1:0]  acc_reg, acc_next;
    logic [DER_W-1:0]    q_reg, q_next;
    logic [DER_W-1:0]    mab_reg, mab_next;
    logic [55:0]         t1_reg, t1_next;
    logic                mv_reg, mv_next;
    logic [SAMPLE_W-1:0] odata_reg, odata_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic               div_start;
    logic               div_done;
    logic [DIV_N_W-1:0] div_q;

    logic [32:0]          diff;
    logic [47:0]          p_full;
    logic [38:0]          p_clamp;
    logic [21:0]          y_val;
    logic [LOG2_EXP_DEPTH-1:0] tab_idx;
    logic [ALPHA_W-1:0]   tab0, tab1;
    logic [ALPHA_W-1:0]   dp;
    logic [ALPHA_W-1:0]   e_val;
    logic [DER_W-1:0]     lim;
    logic [DER_W-1:0]     dmag;
    logic [DER_W+1:0]     d_lp;
    logic [DER_W+1:0]     d_neg;
    logic [79:0]          lp_sum;
    logic [DER_W:0]       lp_res;
    logic [MUL_P_W-1:0]   cut_sum;
    logic                 cut_sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata = odata_reg;
    assign cfg_ready = 1'b1;

    oeaf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    oeaf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod[DIV_N_W-1:0]),
        .divisor  (us_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign diff = {s_tdata[31], s_tdata[31:0]} - {prev_reg[31], prev_reg};
    assign p_full = prod[47:0];
    assign p_clamp = (p_full > 48'(PROD_LIMIT)) ? PROD_LIMIT : p_full[38:0];
    assign y_val = prod[37:16];
    assign tab_idx = y_val[15:16-LOG2_EXP_DEPTH];
    assign tab0 = EXP2_TAB[{1'b0, tab_idx}];
    assign tab1 = EXP2_TAB[{1'b0, tab_idx} + 1'b1];
    assign dp = prod[46:16];
    assign e_val = v_reg >> ip_reg;
    assign lim = neg_reg ? DER_NEG_LIM : DER_POS_LIM;
    assign dmag = (div_q > DIV_N_W'(lim)) ? lim : div_q[DER_W-1:0];
    assign d_lp = {lp_in_reg[DER_W], lp_in_reg} - {lp_out_reg[DER_W], lp_out_reg};
    assign d_neg = -d_lp;
    assign lp_sum = {8'd0, acc_reg} + {prod[63:0], 16'd0};
    assign lp_res = ge_reg ? lp_out_reg + {1'b0, q_reg} : lp_out_reg - {1'b0, q_reg};
    assign cut_sum = prod + {16'd0, t1_reg} + {40'd0, min_cut_reg};
    assign cut_sat = (beta_reg[31:16] != 16'd0) && (mab_reg[47:32] != 16'd0);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DMUL: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MEGA;
            end
            ST_PMUL: begin
                mul_a = MUL_A_W'(fc_reg);
                mul_b = MUL_B_W'(us_reg);
            end
            ST_XMUL: begin
                mul_a = MUL_A_W'(p_clamp);
                mul_b = TWO_PI_PER_MEGA_Q40;
            end
            ST_YMUL: begin
                mul_a = MUL_A_W'(prod[60:40]);
                mul_b = LOG2E_Q16;
            end
            ST_FMUL: begin
                mul_a = MUL_A_W'(dd_reg);
                mul_b = MUL_B_W'(fr_reg);
            end
            ST_LPLO: begin
                mul_a = md_reg;
                mul_b = MUL_B_W'(alpha_reg[15:0]);
            end
            ST_LPHI: begin
                mul_a = md_reg;
                mul_b = MUL_B_W'(alpha_reg[ALPHA_W-1:16]);
            end
            ST_CLO: begin
                mul_a = mab_reg;
                mul_b = MUL_B_W'(beta_reg[15:0]);
            end
            ST_CHI: begin
                mul_a = mab_reg;
                mul_b = MUL_B_W'(beta_reg[31:16]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        first_next = first_reg;
        prev_next = prev_reg;
        sd_next = sd_reg;
        fv_next = fv_reg;
        min_cut_next = min_cut_reg;
        beta_next = beta_reg;
        dcut_next = dcut_reg;
        samp_next = samp_reg;
        us_next = us_reg;
        neg_next = neg_reg;
        mag_next = mag_reg;
        pass_next = pass_reg;
        fc_next = fc_reg;
        ip_next = ip_reg;
        fr_next = fr_reg;
        t0_next = t0_reg;
        dd_next = dd_reg;
        dir_next = dir_reg;
        v_next = v_reg;
        alpha_next = alpha_reg;
        lp_in_next = lp_in_reg;
        lp_out_next = lp_out_reg;
        ge_next = ge_reg;
        md_next = md_reg;
        acc_next = acc_reg;
        q_next = q_reg;
        mab_next = mab_reg;
        t1_next = t1_reg;
        mv_next = mv_reg && !m_tready;
        odata_next = odata_reg;
        div_start = 1'b0;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_CUTOFF: min_cut_next = cfg_data;
                CFG_BETA:       beta_next = cfg_data;
                CFG_D_CUTOFF:   dcut_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    samp_next = s_tdata[31:0];
                    us_next = (s_tdata[47:32] == 16'd0) ? 16'd1 : s_tdata[47:32];
                    prev_next = s_tdata[31:0];
                    if (first_reg) begin
                        first_next = 1'b0;
                        sd_next = '0;
                        fv_next = s_tdata[31:0];
                        state_next = ST_DONE;
                    end else begin
                        neg_next = diff[32];
                        mag_next = diff[32] ? -diff : diff;
                        state_next = ST_DMUL;
                    end
                end
            end
            ST_DMUL: state_next = ST_DIV;
            ST_DIV: begin
                div_start = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (div_done) begin
                    lp_in_next = neg_reg ? -{1'b0, dmag} : {1'b0, dmag};
                    lp_out_next = {sd_reg[DER_W-1], sd_reg};
                    fc_next = dcut_reg;
                    pass_next = 1'b0;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL: state_next = ST_XMUL;
            ST_XMUL: state_next = ST_YMUL;
            ST_YMUL: state_next = ST_TAB;
            ST_TAB: begin
                ip_next = y_val[21:16];
                fr_next = {y_val[15-LOG2_EXP_DEPTH:0], LOG2_EXP_DEPTH'(0)};
                t0_next = tab0;
                dir_next = (tab0 >= tab1);
                dd_next = (tab0 >= tab1) ? tab0 - tab1 : tab1 - tab0;
                if (y_val[21:16] >= 6'd31) begin
                    alpha_next = ALPHA_W'(Q30_ONE);
                    state_next = ST_LPDIF;
                end else begin
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL: state_next = ST_INTERP;
            ST_INTERP: begin
                v_next = dir_reg ? t0_reg - dp : t0_reg + dp;
                state_next = ST_ALPHA;
            end
            ST_ALPHA: begin
                alpha_next = (e_val >= ALPHA_W'(Q30_ONE)) ? '0 : ALPHA_W'(Q30_ONE) - e_val;
                state_next = ST_LPDIF;
            end
            ST_LPDIF: begin
                ge_next = !d_lp[DER_W+1];
                md_next = d_lp[DER_W+1] ? d_neg[DER_W-1:0] : d_lp[DER_W-1:0];
                state_next = ST_LPLO;
            end
            ST_LPLO: state_next = ST_LPHI;
            ST_LPHI: begin
                acc_next = prod;
                state_next = ST_LPSUM;
            end
            ST_LPSUM: begin
                q_next = lp_sum[77:30];
                state_next = ST_LPRES;
            end
            ST_LPRES: begin
                if (!pass_reg) begin
                    sd_next = lp_res[DER_W-1:0];
                    state_next = ST_CABS;
                end else begin
                    fv_next = lp_res[SAMPLE_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_CABS: begin
                mab_next = sd_reg[DER_W-1] ? -sd_reg : sd_reg;
                state_next = ST_CLO;
            end
            ST_CLO: state_next = ST_CHI;
            ST_CHI: begin
                t1_next = prod[71:16];
                state_next = ST_CSUM;
            end
            ST_CSUM: begin
                fc_next = (cut_sat || (cut_sum[71:32] != 40'd0)) ? '1 : cut_sum[31:0];
                lp_in_next = {{(DER_W-SAMPLE_W+1){samp_reg[SAMPLE_W-1]}}, samp_reg};
                lp_out_next = {{(DER_W-SAMPLE_W+1){fv_reg[SAMPLE_W-1]}}, fv_reg};
                pass_next = 1'b1;
                state_next = ST_PMUL;
            end
            ST_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    odata_next = fv_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b1;
            prev_reg <= '0;
            sd_reg <= '0;
            fv_reg <= '0;
            min_cut_reg <= 32'h0001_0000;
            beta_reg <= '0;
            dcut_reg <= 32'h0001_0000;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
            prev_reg <= prev_next;
            sd_reg <= sd_next;
            fv_reg <= fv_next;
            min_cut_reg <= min_cut_next;
            beta_reg <= beta_next;
            dcut_reg <= dcut_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg <= samp_next;
        us_reg <= us_next;
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        pass_reg <= pass_next;
        fc_reg <= fc_next;
        ip_reg <= ip_next;
        fr_reg <= fr_next;
        t0_reg <= t0_next;
        dd_reg <= dd_next;
        dir_reg <= dir_next;
        v_reg <= v_next;
        alpha_reg <= alpha_next;
        lp_in_reg <= lp_in_next;
        lp_out_reg <= lp_out_next;
        ge_reg <= ge_next;
        md_reg <= md_next;
        acc_reg <= acc_next;
        q_reg <= q_next;
        mab_reg <= mab_next;
        t1_reg <= t1_next;
        odata_reg <= odata_next;
    end

endmodule

// ===== rtl/oeaf_checker.sv =====
`timescale 1ns / 1ps
module oeaf_checker
    import oeaf_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata
);

    // The block works on one sample at a time, so it is busy right after a transaction.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a sample was in progress");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before transaction");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

endmodule

bind one_euro_adaptive_filter oeaf_checker u_oeaf_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import oeaf_pkg::*;

    class one_euro_predictor;
        longint unsigned exp2_q30 [EXP_DEPTH+1];
        logic [31:0] min_cut;
        logic [31:0] speed_gain;
        logic [31:0] deriv_cut;
        bit awaiting_first;
        longint last_sample;
        longint deriv_smooth;
        longint filt_value;
        logic [SAMPLE_W-1:0] expected_filtered [$];
        int mismatches;

        function new();
            longint unsigned arg;
            longint unsigned term;
            longint acc;
            for (int k = 0; k <= EXP_DEPTH; k++) begin
                arg = (longint'(k) * 64'd744261118) / EXP_DEPTH;
                term = 64'd1 << 30;
                acc = longint'(64'd1 << 30);
                for (int n = 1; n <= 20; n++) begin
                    term = ((term * arg) >> 30) / longint'(n);
                    acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
                end
                exp2_q30[k] = (acc < 0) ? 0 : longint'(acc);
            end
            min_cut = 32'h0001_0000;
            speed_gain = 32'h0;
            deriv_cut = 32'h0001_0000;
            awaiting_first = 1'b1;
            last_sample = 0;
            deriv_smooth = 0;
            filt_value = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [31:0] val);
            case (idx)
                CFG_MIN_CUTOFF: min_cut = val;
                CFG_BETA: speed_gain = val;
                CFG_D_CUTOFF: deriv_cut = val;
                default: ;
            endcase
        endfunction

        function longint unsigned smoothing_coef(logic [31:0] fc, longint unsigned us);
            longint unsigned p, x, y, ip, pos, idx, fr, t0, t1, v, e;
            p = longint'(fc) * us;
            if (p > (64'd1 << 38)) p = 64'd1 << 38;
            x = (p * 64'd6908435) >> 40;
            y = (x * 64'd94548) >> 16;
            ip = y >> 16;
            if (ip >= 31) return 64'd1 << 30;
            pos = (y & 64'hFFFF) * EXP_DEPTH;
            idx = pos >> 16;
            fr = pos & 64'hFFFF;
            if (idx >= EXP_DEPTH) idx = EXP_DEPTH - 1;
            t0 = exp2_q30[idx];
            t1 = exp2_q30[idx+1];
            v = (t0 >= t1) ? t0 - (((t0 - t1) * fr) >> 16) : t0 + (((t1 - t0) * fr) >> 16);
            e = v >> ip;
            return (e >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - e;
        endfunction

        function longint unsigned scale_q30(longint unsigned m, longint unsigned a);
            longint unsigned hi, lo, q;
            hi = m >> 20;
            lo = m & 64'hFFFFF;
            q = hi * a;
            return (q >> 10) + ((((q & 64'h3FF) << 20) + lo * a) >> 30);
        endfunction

        function longint smooth_step(longint cur, longint target, longint unsigned a);
            if (target >= cur) return cur + longint'(scale_q30(longint'(target - cur), a));
            return cur - longint'(scale_q30(longint'(cur - target), a));
        endfunction

        function longint rate_of_change(longint diff, longint unsigned us);
            bit neg;
            longint unsigned m, q, r, lim, mag;
            neg = diff < 0;
            m = neg ? longint'(-diff) : longint'(diff);
            q = m / us;
            r = m % us;
            lim = neg ? (64'd1 << 47) : (64'd1 << 47) - 1;
            if (q > lim / 1000000) begin
                mag = lim;
            end else begin
                mag = q * 1000000 + (r * 1000000) / us;
                if (mag > lim) mag = lim;
            end
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function logic [31:0] speed_cutoff(longint d);
            longint unsigned m, bh, bl, t;
            m = (d < 0) ? longint'(-d) : longint'(d);
            bh = speed_gain >> 16;
            bl = speed_gain & 32'hFFFF;
            if (bh != 0 && m > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
            t = m * bh + ((m * bl) >> 16) + longint'(min_cut);
            return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        endfunction

        function void note_sample(logic [31:0] raw, logic [15:0] interval);
            longint s;
            longint unsigned us;
            longint dx;
            s = longint'(signed'(raw));
            us = (interval == 0) ? 1 : longint'(interval);
            if (awaiting_first) begin
                awaiting_first = 1'b0;
                last_sample = s;
                deriv_smooth = 0;
                filt_value = s;
            end else begin
                dx = rate_of_change(s - last_sample, us);
                last_sample = s;
                deriv_smooth = smooth_step(deriv_smooth, dx, smoothing_coef(deriv_cut, us));
                filt_value = smooth_step(filt_value, s,
                                         smoothing_coef(speed_cutoff(deriv_smooth), us));
            end
            expected_filtered.push_back(filt_value[SAMPLE_W-1:0]);
        endfunction

        function void check_filtered(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (expected_filtered.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: filtered=%h", got);
                return;
            end
            want = expected_filtered.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch on filtered: expected %h, actual %h", want, got);
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [47:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [SAMPLE_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    one_euro_predictor filter_model;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    logic [31:0] walk_sample;

    one_euro_adaptive_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("FAIL one_euro_adaptive_filter");
        $finish;
    end

    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) filter_model.check_filtered(m_tdata);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_sample(logic [31:0] raw, logic [15:0] interval);
        s_tvalid <= 1'b1;
        s_tdata <= {interval, raw};
        do @(posedge aclk); while (!s_tready);
        filter_model.note_sample(raw, interval);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (filter_model.expected_filtered.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        filter_model.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_cfg();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h0;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(32'h0100_0000);
            default: return $urandom_range(32'h0010_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(9))
            0, 1: walk_sample = $urandom;
            2: walk_sample = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: ;
            default: walk_sample = walk_sample +
                (($urandom_range(1) ? 32'd1 : -32'd1) * $urandom_range(1 << $urandom_range(24)));
        endcase
        return walk_sample;
    endfunction

    function automatic logic [15:0] pick_interval();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(1, 5000));
        if (r < 95) return 16'($urandom);
        case ($urandom_range(2))
            0: return 16'd0;
            1: return 16'd1;
            default: return 16'hFFFF;
        endcase
    endfunction

    initial begin
        filter_model = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        walk_sample = 32'h0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MIN_CUTOFF;
        cfg_data <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(32'h7FFF_FFFF, 16'd1);
        send_sample(32'h8000_0000, 16'hFFFF);
        send_sample(32'h0000_0000, 16'd0);
        send_sample(32'h7FFF_FFFF, 16'd1);
        send_sample(32'h0001_0000, 16'd1000);
        send_sample(32'hFFFF_0000, 16'd1000);
        send_sample(32'h8000_0000, 16'd1);
        drain();
        write_reg(CFG_MIN_CUTOFF, 32'hFFFF_FFFF);
        write_reg(CFG_BETA, 32'hFFFF_FFFF);
        write_reg(CFG_D_CUTOFF, 32'hFFFF_FFFF);
        send_sample(32'h1234_5678, 16'hFFFF);
        send_sample(32'h8000_0000, 16'd1);
        send_sample(32'h7FFF_FFFF, 16'd1);
        send_sample(32'h0000_0000, 16'd0);
        drain();
        write_reg(CFG_MIN_CUTOFF, 32'h0);
        write_reg(CFG_BETA, 32'h0);
        write_reg(CFG_D_CUTOFF, 32'h0);
        send_sample(32'h7FFF_FFFF, 16'hFFFF);
        send_sample(32'h8000_0000, 16'd1);
        send_sample(32'h0005_0000, 16'd200);
        drain();
        write_reg(CFG_MIN_CUTOFF, 32'h0);
        write_reg(CFG_BETA, 32'h0001_0000);
        write_reg(CFG_D_CUTOFF, 32'h0010_0000);
        send_sample(32'h7FFF_FFFF, 16'd1);
        send_sample(32'h8000_0000, 16'd1);
        send_sample(32'h0000_0000, 16'd500);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 57; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 57; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            write_reg(CFG_MIN_CUTOFF, pick_cfg());
            write_reg(CFG_BETA, pick_cfg());
            write_reg(CFG_D_CUTOFF, pick_cfg());
            for (int i = 0; i < 110; i++) begin
                if (ph == 2 && i == 20) hold_request = 400;
                if (ph == 5 && i == 55) drain();
                send_sample(pick_sample(), pick_interval());
            end
            drain();
        end

        repeat (100) @(posedge aclk);
        if (filter_model.mismatches == 0 && filter_model.expected_filtered.size() == 0) begin
            $display("PASS one_euro_adaptive_filter");
        end else begin
            $display("FAIL one_euro_adaptive_filter");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/oeaf_pkg.sv
rtl/oeaf_mul.sv
rtl/oeaf_div.sv
rtl/one_euro_adaptive_filter.sv
rtl/oeaf_checker.sv
tb/sv/testbench.sv
